// ===== src/vtyp_pkg.sv =====
// vtyp_pkg: constants, types and helper functions for the yaw/pitch angle pipeline
// no dependencies; imported by the interfaces' users, the cordic stage and the top level
package vtyp_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int TABLE_MAX     = 32;
  localparam int IDX_W         = 5;
  localparam int DW            = 64;
  localparam int ANG_W         = 48;
  localparam int ANG_FRAC      = 40;
  localparam int OUT_FRAC      = 16;
  localparam int TW            = 49;

  localparam logic [31:0]   INV_GAIN = 32'h9B74EDA8;
  localparam logic [TW-1:0] DEG90_A  = TW'(64'd90 << ANG_FRAC);
  localparam logic [TW-1:0] DEG180_A = TW'(64'd180 << ANG_FRAC);
  localparam logic [TW-1:0] DEG360_A = TW'(64'd360 << ANG_FRAC);
  localparam logic [24:0]   DEG90_Q  = 25'(32'd90 << OUT_FRAC);
  localparam logic [24:0]   DEG270_Q = 25'(32'd270 << OUT_FRAC);
  localparam logic [25:0]   DEG360_Q = 26'(32'd360 << OUT_FRAC);

  typedef logic signed [ANG_W-1:0] ang_tab_t [TABLE_MAX];

  // per-transaction sign and zero flags of the input vector
  typedef struct packed {
    logic vert;
    logic xzero;
    logic xneg;
    logic yneg;
    logic ygt0;
    logic zgt0;
    logic zneg;
  } flags_t;

  // arctangent table, atan(2^-i) in degrees * 2^40, from its power series
  function automatic ang_tab_t fill_atan();
    ang_tab_t t;
    logic [63:0] base;
    logic [63:0] term;
    logic signed [63:0] sum;
    int k;
    int sh;
    base = 64'd246083499208 << 8;
    t[0] = ANG_W'(64'd45 << ANG_FRAC);
    for (int i = 1; i < TABLE_MAX; i++) begin
      sum = '0;
      k   = 0;
      sh  = i;
      while (sh < 64) begin
        term = (base >> sh) / 64'(2 * k + 1);
        if ((k & 1) != 0) sum = sum - $signed(term);
        else sum = sum + $signed(term);
        k  = k + 1;
        sh = i * (2 * k + 1);
      end
      t[i] = ANG_W'(sum);
    end
    return t;
  endfunction

  localparam ang_tab_t ATAN_TAB = fill_atan();

  // clamp a first-quadrant angle to [0, 90 degrees]
  function automatic logic [TW-1:0] clamp_q1(input logic signed [ANG_W-1:0] z);
    logic [TW-1:0] r;
    if (z[ANG_W-1]) r = '0;
    else if (TW'(z) > DEG90_A) r = DEG90_A;
    else r = TW'(z);
    return r;
  endfunction

  // round half up to Q9.16 and wrap 360 to 0
  function automatic logic [24:0] to_q16(input logic [TW-1:0] a);
    logic [TW:0] s;
    logic [25:0] r;
    s = {1'b0, a} + (TW + 1)'(64'd1 << (ANG_FRAC - OUT_FRAC - 1));
    r = 26'(s >> (ANG_FRAC - OUT_FRAC));
    if (r >= DEG360_Q) r = r - DEG360_Q;
    return 25'(r);
  endfunction

endpackage

// ===== src/vtyp_if.sv =====
// vtyp_in_if / vtyp_out_if: valid-ready channels of the yaw/pitch angle pipeline
// no dependencies
interface vtyp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface vtyp_out_if;
  logic               valid;
  logic               ready;
  logic signed [25:0] pitch_angle;
  logic        [24:0] yaw_angle;
  modport source (output valid, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, pitch_angle, yaw_angle, output ready);
endinterface

// ===== src/vtyp_cordic_stage.sv =====
// vtyp_cordic_stage: one registered vectoring cordic iteration
// depends on vtyp_pkg (widths, arctangent table)
module vtyp_cordic_stage import vtyp_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [IDX_W-1:0]        idx,
  input  logic signed [DW-1:0]    x_in,
  input  logic signed [DW-1:0]    y_in,
  input  logic signed [ANG_W-1:0] z_in,
  output logic signed [DW-1:0]    x_out,
  output logic signed [DW-1:0]    y_out,
  output logic signed [ANG_W-1:0] z_out
);

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;

  // floor shifts of the cross terms
  assign dx = y_in >>> idx;
  assign dy = x_in >>> idx;

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[DW-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN_TAB[idx];
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN_TAB[idx];
      end
    end
  end

endmodule

// ===== src/vector_to_yaw_pitch_angles.sv =====
// vector_to_yaw_pitch_angles: direction vector to yaw and negated pitch, fully pipelined
// depends on vtyp_pkg, vtyp_if (channels) and vtyp_cordic_stage
//
//  channel  dir  payload                                   role
//  vec      in   vec_x, vec_y, vec_z (signed Q16.16)       direction vector
//  angles   out  pitch_angle (s26 Q9.16), yaw_angle (u25)  negated pitch, yaw
//
// one transaction per cycle unless angles stalls; stages in order: 0, 1, 2, the first
// cordic chain, d, e, second chain, output register; one iteration per cordic stage
// rst (synchronous) clears the valid bits of every stage and the output register
// a stall on angles freezes the whole pipeline; vec.ready drops in the same cycle
module vector_to_yaw_pitch_angles import vtyp_pkg::*; (
  input logic        clk,
  input logic        rst,
  vtyp_in_if.sink    vec,
  vtyp_out_if.source angles
);

  localparam int N = CORDIC_STAGES;

  logic en;
  logic out_valid;
  logic [25:0] pitch_q;
  logic [24:0] yaw_q;

  assign en        = !out_valid || angles.ready;
  assign vec.ready = en;

  // stage 0: magnitudes, flags, largest magnitude
  logic        v0;
  logic [31:0] ax0, ay0, az0, m0;
  flags_t      f0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= vec.valid;
  end
  always_ff @(posedge clk) begin
    logic [31:0] ax, ay, az, m;
    if (en) begin
      ax = vec.vec_x[31] ? 32'(-vec.vec_x) : 32'(vec.vec_x);
      ay = vec.vec_y[31] ? 32'(-vec.vec_y) : 32'(vec.vec_y);
      az = vec.vec_z[31] ? 32'(-vec.vec_z) : 32'(vec.vec_z);
      m  = (ay > ax) ? ay : ax;
      if (az > m) m = az;
      ax0 <= ax;
      ay0 <= ay;
      az0 <= az;
      m0  <= m;
      f0.vert  <= (vec.vec_x == 0) && (vec.vec_y == 0);
      f0.xzero <= (vec.vec_x == 0);
      f0.xneg  <= vec.vec_x[31];
      f0.yneg  <= vec.vec_y[31];
      f0.ygt0  <= !vec.vec_y[31] && (vec.vec_y != 0);
      f0.zgt0  <= !vec.vec_z[31] && (vec.vec_z != 0);
      f0.zneg  <= vec.vec_z[31];
    end
  end

  // stage 1: leading one search gives the normalizing shift
  logic        v1;
  logic [31:0] ax1, ay1, az1;
  logic [5:0]  s1;
  flags_t      f1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    logic [5:0] msb;
    if (en) begin
      msb = '0;
      for (int b = 0; b < 32; b++) begin
        if (m0[b]) msb = 6'(b);
      end
      s1  <= 6'(59) - msb;
      ax1 <= ax0;
      ay1 <= ay0;
      az1 <= az0;
      f1  <= f0;
    end
  end

  // stage 2: normalize so the largest magnitude lies in [2^59, 2^60)
  logic                    c1v [N+1];
  logic signed [DW-1:0]    c1x [N+1];
  logic signed [DW-1:0]    c1y [N+1];
  logic signed [ANG_W-1:0] c1z [N+1];
  logic [DW-1:0]           c1az [N+1];
  flags_t                  c1f [N+1];
  always_ff @(posedge clk) begin
    if (rst) c1v[0] <= 1'b0;
    else if (en) c1v[0] <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1x[0]  <= $signed({32'd0, ax1} << s1);
      c1y[0]  <= $signed({32'd0, ay1} << s1);
      c1z[0]  <= '0;
      c1az[0] <= {32'd0, az1} << s1;
      c1f[0]  <= f1;
    end
  end

  // first cordic chain: yaw angle and horizontal length
  for (genvar g = 0; g < N; g++) begin : g_yaw
    vtyp_cordic_stage u_stage (
      .clk   (clk),
      .en    (en),
      .idx   (IDX_W'(g)),
      .x_in  (c1x[g]),
      .y_in  (c1y[g]),
      .z_in  (c1z[g]),
      .x_out (c1x[g+1]),
      .y_out (c1y[g+1]),
      .z_out (c1z[g+1])
    );
    always_ff @(posedge clk) begin
      if (rst) c1v[g+1] <= 1'b0;
      else if (en) c1v[g+1] <= c1v[g];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c1az[g+1] <= c1az[g];
        c1f[g+1]  <= c1f[g];
      end
    end
  end

  // stage d: clamp yaw angle, gain correction partial products
  logic          vd;
  logic [TW-1:0] ad;
  logic [63:0]   hi_d, lo_d;
  logic [DW-1:0] az_d;
  flags_t        fd;
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (en) vd <= c1v[N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ad   <= clamp_q1(c1z[N]);
      hi_d <= 64'(c1x[N][63:32]) * 64'(INV_GAIN);
      lo_d <= 64'(c1x[N][31:0]) * 64'(INV_GAIN);
      az_d <= c1az[N];
      fd   <= c1f[N];
    end
  end

  // stage e: horizontal length and yaw in its quadrant
  logic                    c2v [N+1];
  logic signed [DW-1:0]    c2x [N+1];
  logic signed [DW-1:0]    c2y [N+1];
  logic signed [ANG_W-1:0] c2z [N+1];
  logic [24:0]             c2yaw [N+1];
  flags_t                  c2f [N+1];
  always_ff @(posedge clk) begin
    if (rst) c2v[0] <= 1'b0;
    else if (en) c2v[0] <= vd;
  end
  always_ff @(posedge clk) begin
    logic [TW-1:0] t;
    if (en) begin
      if (!fd.xneg) t = fd.yneg ? (DEG360_A - ad) : ad;
      else t = fd.yneg ? (DEG180_A + ad) : (DEG180_A - ad);
      if (fd.vert) c2yaw[0] <= '0;
      else if (fd.xzero) c2yaw[0] <= fd.ygt0 ? DEG90_Q : DEG270_Q;
      else c2yaw[0] <= to_q16(t);
      c2x[0] <= $signed(hi_d + (lo_d >> 32));
      c2y[0] <= $signed(az_d);
      c2z[0] <= '0;
      c2f[0] <= fd;
    end
  end

  // second cordic chain: pitch angle
  for (genvar g = 0; g < N; g++) begin : g_pitch
    vtyp_cordic_stage u_stage (
      .clk   (clk),
      .en    (en),
      .idx   (IDX_W'(g)),
      .x_in  (c2x[g]),
      .y_in  (c2y[g]),
      .z_in  (c2z[g]),
      .x_out (c2x[g+1]),
      .y_out (c2y[g+1]),
      .z_out (c2z[g+1])
    );
    always_ff @(posedge clk) begin
      if (rst) c2v[g+1] <= 1'b0;
      else if (en) c2v[g+1] <= c2v[g];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c2yaw[g+1] <= c2yaw[g];
        c2f[g+1]   <= c2f[g];
      end
    end
  end

  // output register: pitch quadrant, rounding, negation
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= c2v[N];
  end
  always_ff @(posedge clk) begin
    logic [TW-1:0] b;
    logic [24:0]   p;
    if (en) begin
      b = clamp_q1(c2z[N]);
      if (c2f[N].vert) p = c2f[N].zgt0 ? DEG90_Q : DEG270_Q;
      else p = to_q16(c2f[N].zneg ? (DEG360_A - b) : b);
      pitch_q <= 26'(-{1'b0, p});
      yaw_q   <= c2yaw[N];
    end
  end

  assign angles.valid       = out_valid;
  assign angles.pitch_angle = $signed(pitch_q);
  assign angles.yaw_angle   = yaw_q;

  // yaw stays below a full turn
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (26'(yaw_q) < DEG360_Q))
    else $error("yaw out of range");

  // negated pitch stays in (-360, 0]
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_q == '0 || (pitch_q[25] && (26'(-pitch_q) < DEG360_Q))))
    else $error("pitch out of range");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
